// ----- src/effc_pkg.sv -----
// Package for the extended float format converter: command codes,
// rounding mode codes and format constants. No dependencies.
package effc_pkg;

   typedef logic [2:0] cmd_type;
   typedef logic [1:0] rmode_type;

   localparam cmd_type CMD_S2X = 3'd0;
   localparam cmd_type CMD_D2X = 3'd1;
   localparam cmd_type CMD_X2S = 3'd2;
   localparam cmd_type CMD_X2D = 3'd3;
   localparam cmd_type CMD_X2I = 3'd4;
   localparam cmd_type CMD_I2X = 3'd5;

   localparam rmode_type RM_NEAREST = 2'd0;
   localparam rmode_type RM_DOWN    = 2'd1;
   localparam rmode_type RM_UP      = 2'd2;
   localparam rmode_type RM_TRUNC   = 2'd3;

   localparam logic [14:0] EXT_BIAS = 15'd16383;
   localparam logic [14:0] SGL_BIAS = 15'd127;
   localparam logic [14:0] DBL_BIAS = 15'd1023;

endpackage

// ----- src/extended_float_format_converter.sv -----
// Top level of the extended float format converter: input register,
// rounding mode register and result register around effc_core.
// Depends on effc_pkg and effc_core.
//
// One item per cycle while rsp_stall is low: an accepted item sits in the
// input register, passes effc_core and lands in the result register,
// where its result is offered. A stalled result holds in place and the
// input register keeps its item, so req_stall follows rsp_stall only when
// both stages are full. The rounding mode applies to items still in
// flight.
module extended_float_format_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  effc_pkg::cmd_type    req_cmd,
   input  logic                 req_sign_in,
   input  logic [14:0]          req_exponent_in,
   input  logic [63:0]          req_mantissa_in,
   input  logic [63:0]          req_packed_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_sign_out,
   output logic [14:0]          rsp_exponent_out,
   output logic [63:0]          rsp_mantissa_out,
   output logic [63:0]          rsp_packed_out,
   output logic                 rsp_overflow,
   input  logic                 csr_write,
   input  effc_pkg::rmode_type  csr_wdata
);
   import effc_pkg::*;

   rmode_type   rmode_ff;
   logic        in_valid_ff;
   cmd_type     cmd_ff;
   logic        sign_ff;
   logic [14:0] exp_ff;
   logic [63:0] man_ff;
   logic [63:0] pk_ff;
   logic        out_valid_ff;

   logic        c_sign;
   logic [14:0] c_exp;
   logic [63:0] c_man;
   logic [63:0] c_pk;
   logic        c_ov;
   logic        out_load_in;
   logic        in_load_in;

   // Result stage takes a new item whenever it is empty or being drained.
   assign out_load_in = !out_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !out_load_in;
   assign in_load_in  = !req_stall;

   effc_core u_core (
      .cmd(cmd_ff), .rmode(rmode_ff), .sign_in(sign_ff), .exponent_in(exp_ff),
      .mantissa_in(man_ff), .packed_in(pk_ff), .sign_out(c_sign),
      .exponent_out(c_exp), .mantissa_out(c_man), .packed_out(c_pk),
      .overflow(c_ov)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rmode_ff     <= RM_NEAREST;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) rmode_ff <= csr_wdata;
         if (in_load_in) in_valid_ff <= req_valid;
         if (out_load_in) out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load_in && req_valid) begin
         cmd_ff  <= req_cmd;
         sign_ff <= req_sign_in;
         exp_ff  <= req_exponent_in;
         man_ff  <= req_mantissa_in;
         pk_ff   <= req_packed_in;
      end
      if (out_load_in && in_valid_ff) begin
         rsp_sign_out     <= c_sign;
         rsp_exponent_out <= c_exp;
         rsp_mantissa_out <= c_man;
         rsp_packed_out   <= c_pk;
         rsp_overflow     <= c_ov;
      end
   end

   assign rsp_valid = out_valid_ff;

   // Stall back-pressure only arises with both stages full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("req_stall without full pipeline");
   // A held result with a full input stage keeps the input stage full.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && in_valid_ff) |=> in_valid_ff)
      else $error("input stage lost an item under stall");
   // Overflow only flags on the integer command.
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      (out_load_in && in_valid_ff && c_ov) |-> (cmd_ff == CMD_X2I))
      else $error("overflow on non-integer command");

endmodule

// ----- src/effc_core.sv -----
// Combinational conversion datapath for all six commands.
// Depends on effc_pkg.
module effc_core (
   input  effc_pkg::cmd_type   cmd,
   input  effc_pkg::rmode_type rmode,
   input  logic                sign_in,
   input  logic [14:0]         exponent_in,
   input  logic [63:0]         mantissa_in,
   input  logic [63:0]         packed_in,
   output logic                sign_out,
   output logic [14:0]         exponent_out,
   output logic [63:0]         mantissa_out,
   output logic [63:0]         packed_out,
   output logic                overflow
);
   import effc_pkg::*;

   logic [31:0]  sgl_w;
   logic [31:0]  sgl_r;
   logic         sgl_up;
   logic [39:0]  sgl_disc;
   logic [63:0]  dbl_r;
   logic         dbl_up;
   logic [10:0]  dbl_disc;
   logic [15:0]  shift;
   logic [127:0] wide;
   logic [63:0]  iv;
   logic [31:0]  frac;
   logic         int_up;
   logic [5:0]   lz;
   logic         lz_found;
   logic [63:0]  norm;

   always_comb begin
      sgl_w    = packed_in[31:0];
      sgl_disc = mantissa_in[39:0];
      sgl_r    = {sign_in, 8'(exponent_in - EXT_BIAS + SGL_BIAS), mantissa_in[62:40]};
      unique case (rmode)
         RM_NEAREST: sgl_up = sgl_disc > 40'h8000000000;
         RM_DOWN:    sgl_up = sign_in && (sgl_disc != '0);
         RM_UP:      sgl_up = !sign_in && (sgl_disc != '0);
         default:    sgl_up = 1'b0;
      endcase
      dbl_disc = mantissa_in[10:0];
      dbl_r    = {sign_in, 11'(exponent_in - EXT_BIAS + DBL_BIAS), mantissa_in[62:11]};
      unique case (rmode)
         RM_NEAREST: dbl_up = dbl_disc > 11'h400;
         RM_DOWN:    dbl_up = sign_in && (dbl_disc != '0);
         RM_UP:      dbl_up = !sign_in && (dbl_disc != '0);
         default:    dbl_up = 1'b0;
      endcase
   end

   // Integer path: shift = bias+63-e, kept signed in 16 bits.
   always_comb begin
      shift = 16'(EXT_BIAS) + 16'd63 - {1'b0, exponent_in};
      wide  = {mantissa_in, 64'd0} >> shift[6:0];
      iv    = '0;
      frac  = '0;
      if (!shift[15] && shift < 16'd64) begin
         iv   = wide[127:64];
         frac = wide[63:32];
      end else if (!shift[15] && shift < 16'd96) begin
         frac = wide[63:32];
      end
      unique case (rmode)
         RM_NEAREST: int_up = (frac > 32'h80000000) || ((frac == 32'h80000000) && iv[0]);
         RM_DOWN:    int_up = sign_in && (frac != '0);
         RM_UP:      int_up = !sign_in && (frac != '0);
         default:    int_up = 1'b0;
      endcase
   end

   // Leading-zero count for integer to extended.
   always_comb begin
      lz       = '0;
      lz_found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!lz_found && mantissa_in[i]) begin
            lz       = 6'(63 - i);
            lz_found = 1'b1;
         end
      end
      norm = mantissa_in << lz;
   end

   always_comb begin
      sign_out     = 1'b0;
      exponent_out = '0;
      mantissa_out = '0;
      packed_out   = '0;
      overflow     = 1'b0;
      unique case (cmd)
         CMD_S2X: begin
            sign_out = sgl_w[31];
            if (sgl_w[30:0] != '0) begin
               exponent_out = {7'd0, sgl_w[30:23]} - SGL_BIAS + EXT_BIAS;
               mantissa_out = {1'b1, sgl_w[22:0], 40'd0};
            end
         end
         CMD_D2X: begin
            sign_out = packed_in[63];
            if (packed_in[62:0] != '0) begin
               exponent_out = {4'd0, packed_in[62:52]} - DBL_BIAS + EXT_BIAS;
               mantissa_out = {1'b1, packed_in[51:0], 11'd0};
            end
         end
         CMD_X2S: begin
            if (exponent_in == '0) packed_out = {32'd0, sign_in, 31'd0};
            else packed_out = {32'd0, sgl_r + 32'(sgl_up)};
         end
         CMD_X2D: begin
            if (exponent_in == '0) packed_out = {sign_in, 63'd0};
            else packed_out = dbl_r + 64'(dbl_up);
         end
         CMD_X2I: begin
            sign_out = sign_in;
            if (shift[15]) overflow = 1'b1;
            else mantissa_out = iv + 64'(int_up);
         end
         CMD_I2X: begin
            if (mantissa_in != '0) begin
               sign_out     = sign_in;
               exponent_out = EXT_BIAS + 15'd63 - 15'(lz);
               mantissa_out = norm;
            end
         end
         default: ;
      endcase
   end

endmodule
